// ===== sv/jsch_pkg.sv =====
// Shared types, codes and ordering function for the job scheduler.
package jsch_pkg;

    localparam logic [1:0] ACT_NEW     = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_QUANTUM = 2'd2;

    localparam logic [1:0] OUT_PLACED   = 2'd0;
    localparam logic [1:0] OUT_DISPATCH = 2'd1;
    localparam logic [1:0] OUT_NONE     = 2'd2;
    localparam logic [1:0] OUT_DROP     = 2'd3;

    localparam logic [2:0] POL_FCFS  = 3'd0;
    localparam logic [2:0] POL_SJF   = 3'd1;
    localparam logic [2:0] POL_PRIO  = 3'd2;
    localparam logic [2:0] POL_PPRIO = 3'd3;
    localparam logic [2:0] POL_RR    = 3'd4;

    localparam logic CFG_CORES  = 1'b0;
    localparam logic CFG_POLICY = 1'b1;

    typedef struct packed {
        logic [7:0]  urgency;
        logic [31:0] run_length;
        logic [31:0] arrival;
        logic [15:0] job_id;
    } t_entry;

    typedef struct packed {
        logic       scan;
        logic       shift;
        logic       write;
        logic [2:0] policy;
    } t_qctl;

    // true when a strictly precedes b, insertion order aside
    function automatic logic ahead(input logic [2:0] pol, input t_entry a, input t_entry b);
        logic r;
        case (pol)
            POL_SJF: begin
                if (a.run_length != b.run_length) r = a.run_length < b.run_length;
                else r = a.arrival < b.arrival;
            end
            POL_PRIO, POL_PPRIO: begin
                if (a.urgency != b.urgency) r = a.urgency < b.urgency;
                else r = a.arrival < b.arrival;
            end
            POL_RR: r = 1'b0;
            default: r = a.arrival < b.arrival;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/multicore_job_scheduler_unit.sv =====
// Multicore job scheduler: core dispatch, preemption and a cell-chain wait queue.
// New job placed, queued or dropped directly: the result is registered in the cycle after the request.
// Preemptive priority with all cores busy: core urgency scan over the cores in use, then the preempt step.
// Finish or quantum with queued jobs: best search runs down the cells, then the take step.
// One request in flight; the next request is taken once the result register is free.
// Synchronous reset: cores idle, queue empty, control state to defaults; job stores not cleared.
module multicore_job_scheduler_unit #(
    parameter int CORE_COUNT  = 8,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // job_id, event_time, run_length, urgency, core_index, zero pad
    input  logic [1:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // answer_value
    output logic [1:0]  m_tuser,  // outcome
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [3:0]  i_cfg_data
);
    localparam int CW = CORE_COUNT > 1 ? $clog2(CORE_COUNT) : 1;
    localparam int UW = $clog2(CORE_COUNT+1);
    localparam int QW = $clog2(QUEUE_DEPTH+1);
    localparam int QI = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CSCAN   = 3'd1;
    localparam logic [2:0] ST_PREEMPT = 3'd2;
    localparam logic [2:0] ST_QSCAN   = 3'd3;
    localparam logic [2:0] ST_TAKE    = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [3:0]       r_cores;
    logic [2:0]       r_policy;
    logic [CORE_COUNT-1:0] r_busy, n_busy;
    logic [QW-1:0]    r_count, n_count;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_outcome, n_outcome;
    logic [15:0]      r_answer, n_answer;
    jsch_pkg::t_entry r_job, n_job;
    logic [CW-1:0]    r_core, n_core;
    logic             r_req, n_req;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_worst, n_worst;
    logic [7:0]       r_worst_urg, n_worst_urg;
    logic             r_found, n_found;
    logic [QI-1:0]    r_qcnt, n_qcnt;

    logic             w_accept;
    logic             w_produce;
    logic [UW-1:0]    w_used;
    logic             w_idle_found;
    logic [CW-1:0]    w_idle_idx;
    logic [1:0]       w_act;
    jsch_pkg::t_entry w_in_job;
    logic [2:0]       w_in_core;
    logic             w_core_ok;
    logic [CW-1:0]    w_c;

    logic             w_cwe;
    logic [CW-1:0]    w_cwaddr;
    jsch_pkg::t_entry w_cwdata;
    logic [CW-1:0]    w_craddr;
    jsch_pkg::t_entry w_crd;

    jsch_pkg::t_qctl  w_ctl;
    logic [QI-1:0]    w_shift_from;
    logic [QI-1:0]    w_wr_idx;
    jsch_pkg::t_entry w_wr_data;
    jsch_pkg::t_entry w_entry   [QUEUE_DEPTH];
    logic             w_tok_v   [QUEUE_DEPTH];
    jsch_pkg::t_entry w_tok     [QUEUE_DEPTH];
    logic [QI-1:0]    w_tok_idx [QUEUE_DEPTH];
    jsch_pkg::t_entry w_best;
    logic [QI-1:0]    w_best_idx;
    logic             w_keep;

    assign w_act     = s_tuser;
    assign w_in_job  = '{urgency: s_tdata[87:80], run_length: s_tdata[79:48],
                         arrival: s_tdata[47:16], job_id: s_tdata[15:0]};
    assign w_in_core = s_tdata[90:88];
    assign w_core_ok = int'(w_in_core) < CORE_COUNT;
    assign w_c       = CW'(w_in_core);

    assign s_tready  = (r_state == ST_IDLE) && (!r_ovalid || m_tready);
    assign w_accept  = s_tvalid && s_tready;
    assign m_tvalid  = r_ovalid;
    assign m_tdata   = r_answer;
    assign m_tuser   = r_outcome;

    always_comb begin
        if (r_cores == 4'd0) w_used = UW'(1);
        else if (int'(r_cores) > CORE_COUNT) w_used = UW'(CORE_COUNT);
        else w_used = UW'(r_cores);
    end

    always_comb begin
        w_idle_found = 1'b0;
        w_idle_idx   = '0;
        for (int i = CORE_COUNT-1; i >= 0; i--) begin
            if (i < int'(w_used) && !r_busy[i]) begin
                w_idle_found = 1'b1;
                w_idle_idx   = CW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cores  <= 4'd8;
            r_policy <= jsch_pkg::POL_FCFS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jsch_pkg::CFG_CORES:  r_cores  <= i_cfg_data;
                jsch_pkg::CFG_POLICY: r_policy <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    jsch_cores #(.CORE_COUNT(CORE_COUNT)) u_cores (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_cwaddr),
        .i_wdata (w_cwdata),
        .i_raddr (w_craddr),
        .o_rdata (w_crd)
    );

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            jsch_pkg::t_entry w_nx;
            logic             w_tv_in;
            jsch_pkg::t_entry w_t_in;
            logic [QI-1:0]    w_ti_in;
            if (g < QUEUE_DEPTH-1) begin : g_mid
                assign w_nx = w_entry[g+1];
            end else begin : g_end
                assign w_nx = w_entry[g];
            end
            if (g == 0) begin : g_head
                assign w_tv_in = 1'b0;
                assign w_t_in  = '0;
                assign w_ti_in = '0;
            end else begin : g_body
                assign w_tv_in = w_tok_v[g-1];
                assign w_t_in  = w_tok[g-1];
                assign w_ti_in = w_tok_idx[g-1];
            end
            jsch_cell #(.QUEUE_DEPTH(QUEUE_DEPTH), .POS(g)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_count      (r_count),
                .i_shift_from (w_shift_from),
                .i_wr_idx     (w_wr_idx),
                .i_wr_data    (w_wr_data),
                .i_next       (w_nx),
                .o_entry      (w_entry[g]),
                .i_tok_valid  (w_tv_in),
                .i_tok        (w_t_in),
                .i_tok_idx    (w_ti_in),
                .o_tok_valid  (w_tok_v[g]),
                .o_tok        (w_tok[g]),
                .o_tok_idx    (w_tok_idx[g])
            );
        end
    endgenerate

    assign w_best     = w_tok[QUEUE_DEPTH-1];
    assign w_best_idx = w_tok_idx[QUEUE_DEPTH-1];
    assign w_keep     = jsch_pkg::ahead(r_policy, w_crd, w_best);

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_count     = r_count;
        n_job       = r_job;
        n_core      = r_core;
        n_req       = r_req;
        n_ptr       = r_ptr;
        n_worst     = r_worst;
        n_worst_urg = r_worst_urg;
        n_found     = r_found;
        n_qcnt      = r_qcnt;
        n_outcome   = r_outcome;
        n_answer    = r_answer;
        w_produce   = 1'b0;
        w_cwe       = 1'b0;
        w_cwaddr    = '0;
        w_cwdata    = r_job;
        w_craddr    = r_core;
        w_ctl       = '{scan: 1'b0, shift: 1'b0, write: 1'b0, policy: r_policy};
        w_shift_from = '0;
        w_wr_idx    = r_count[QI-1:0];
        w_wr_data   = r_job;

        case (r_state)
            ST_IDLE: begin
                w_craddr = w_c;
                if (w_accept) begin
                    n_job  = w_in_job;
                    n_core = w_c;
                    w_produce = 1'b1;
                    n_outcome = jsch_pkg::OUT_NONE;
                    n_answer  = '0;
                    if (w_act == jsch_pkg::ACT_NEW) begin
                        if (w_idle_found) begin
                            w_cwe    = 1'b1;
                            w_cwaddr = w_idle_idx;
                            w_cwdata = w_in_job;
                            n_busy[w_idle_idx] = 1'b1;
                            n_outcome = jsch_pkg::OUT_PLACED;
                            n_answer  = 16'(w_idle_idx);
                        end else if (int'(r_count) >= QUEUE_DEPTH) begin
                            n_outcome = jsch_pkg::OUT_DROP;
                        end else if (r_policy == jsch_pkg::POL_PPRIO) begin
                            w_produce = 1'b0;
                            n_ptr     = '0;
                            n_found   = 1'b0;
                            n_state   = ST_CSCAN;
                        end else begin
                            w_ctl.write = 1'b1;
                            w_wr_data   = w_in_job;
                            n_count     = r_count + QW'(1);
                        end
                    end else if ((w_act == jsch_pkg::ACT_FINISH ||
                                  w_act == jsch_pkg::ACT_QUANTUM) && w_core_ok) begin
                        n_req = (w_act == jsch_pkg::ACT_QUANTUM) && r_busy[w_c];
                        if (!n_req) begin
                            n_busy[w_c] = 1'b0;
                            if (r_count != '0) begin
                                w_produce = 1'b0;
                                n_qcnt    = '0;
                                n_state   = ST_QSCAN;
                            end
                        end else if (r_count == '0) begin
                            n_outcome = jsch_pkg::OUT_DISPATCH;
                            n_answer  = w_crd.job_id;
                        end else begin
                            w_produce = 1'b0;
                            n_qcnt    = '0;
                            n_state   = ST_QSCAN;
                        end
                    end
                end
            end
            ST_CSCAN: begin
                w_craddr = r_ptr;
                if (r_busy[r_ptr] && (!r_found || w_crd.urgency > r_worst_urg)) begin
                    n_found     = 1'b1;
                    n_worst     = r_ptr;
                    n_worst_urg = w_crd.urgency;
                end
                n_ptr = r_ptr + CW'(1);
                if (int'(r_ptr) + 1 >= int'(w_used)) n_state = ST_PREEMPT;
            end
            ST_PREEMPT: begin
                w_craddr    = r_worst;
                w_produce   = 1'b1;
                w_ctl.write = 1'b1;
                n_count     = r_count + QW'(1);
                n_state     = ST_IDLE;
                if (r_found && r_worst_urg > r_job.urgency) begin
                    w_wr_data = w_crd;
                    w_cwe     = 1'b1;
                    w_cwaddr  = r_worst;
                    w_cwdata  = r_job;
                    n_outcome = jsch_pkg::OUT_PLACED;
                    n_answer  = 16'(r_worst);
                end else begin
                    w_wr_data = r_job;
                    n_outcome = jsch_pkg::OUT_NONE;
                    n_answer  = '0;
                end
            end
            ST_QSCAN: begin
                w_ctl.scan = 1'b1;
                n_qcnt = r_qcnt + QI'(1);
                if (r_qcnt == QI'(QUEUE_DEPTH-1)) n_state = ST_TAKE;
            end
            ST_TAKE: begin
                w_produce = 1'b1;
                n_outcome = jsch_pkg::OUT_DISPATCH;
                n_state   = ST_IDLE;
                if (r_req && w_keep) begin
                    n_answer = w_crd.job_id;
                end else begin
                    w_cwe        = 1'b1;
                    w_cwaddr     = r_core;
                    w_cwdata     = w_best;
                    n_busy[r_core] = 1'b1;
                    n_answer     = w_best.job_id;
                    w_ctl.shift  = 1'b1;
                    w_shift_from = w_best_idx;
                    if (r_req) begin
                        w_ctl.write = 1'b1;
                        w_wr_idx    = QI'(r_count - QW'(1));
                        w_wr_data   = w_crd;
                    end else begin
                        n_count = r_count - QW'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_produce) n_ovalid = 1'b1;
        else if (m_tready) n_ovalid = 1'b0;
        else n_ovalid = r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
            r_req    <= 1'b0;
            r_ptr    <= '0;
            r_qcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
            r_req    <= n_req;
            r_ptr    <= n_ptr;
            r_qcnt   <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_outcome   <= n_outcome;
        r_answer    <= n_answer;
        r_job       <= n_job;
        r_core      <= n_core;
        r_worst     <= n_worst;
        r_worst_urg <= n_worst_urg;
    end
endmodule

// ===== sv/jsch_cell.sv =====
// One wait queue cell: holds an entry, passes the running best to its neighbour.
module jsch_cell #(
    parameter int QUEUE_DEPTH = 32,
    parameter int POS         = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  jsch_pkg::t_qctl                 i_ctl,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_count,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]  i_shift_from,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]  i_wr_idx,
    input  jsch_pkg::t_entry                i_wr_data,
    input  jsch_pkg::t_entry                i_next,
    output jsch_pkg::t_entry                o_entry,
    input  logic                            i_tok_valid,
    input  jsch_pkg::t_entry                i_tok,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]  i_tok_idx,
    output logic                            o_tok_valid,
    output jsch_pkg::t_entry                o_tok,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  o_tok_idx
);
    localparam int QW = $clog2(QUEUE_DEPTH+1);
    localparam int QI = $clog2(QUEUE_DEPTH);
    localparam logic [QI-1:0] MY_IDX = QI'(POS);

    jsch_pkg::t_entry r_entry;
    logic             r_tok_valid;
    jsch_pkg::t_entry r_tok;
    logic [QI-1:0]    r_tok_idx;
    logic             w_occupied;
    logic             w_take;

    assign w_occupied = QW'(POS) < i_count;
    assign w_take     = w_occupied &&
                        (!i_tok_valid || jsch_pkg::ahead(i_ctl.policy, r_entry, i_tok));

    always_ff @(posedge i_clk) begin
        if (i_ctl.write && i_wr_idx == MY_IDX) begin
            r_entry <= i_wr_data;
        end else if (i_ctl.shift && MY_IDX >= i_shift_from && POS < QUEUE_DEPTH-1) begin
            r_entry <= i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else if (i_ctl.scan) begin
            r_tok_valid <= w_take || i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_tok     <= w_take ? r_entry : i_tok;
            r_tok_idx <= w_take ? MY_IDX : i_tok_idx;
        end
    end

    assign o_entry     = r_entry;
    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;
    assign o_tok_idx   = r_tok_idx;
endmodule

// ===== sv/jsch_cores.sv =====
// Running job store, one entry per core, one write and one read port.
module jsch_cores #(
    parameter int CORE_COUNT = 8
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [(CORE_COUNT > 1 ? $clog2(CORE_COUNT) : 1)-1:0] i_waddr,
    input  jsch_pkg::t_entry                               i_wdata,
    input  logic [(CORE_COUNT > 1 ? $clog2(CORE_COUNT) : 1)-1:0] i_raddr,
    output jsch_pkg::t_entry                               o_rdata
);
    jsch_pkg::t_entry r_mem [CORE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];
endmodule

// ===== sv/jsch_checker.sv =====
// Port checks for the job scheduler, bound to the top level.
module jsch_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == jsch_pkg::OUT_DROP |-> m_tdata == 16'd0)
        else $error("drop carries nonzero answer");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == jsch_pkg::OUT_NONE |-> m_tdata == 16'd0)
        else $error("idle outcome carries nonzero answer");

    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken with result slot blocked");
endmodule

bind multicore_job_scheduler_unit jsch_checker u_jsch_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
